[rtl/stramp_pkg.sv]
// shared types and constants for the stepper trapezoid ramp core
`timescale 1ns / 1ps
`default_nettype none

package stramp_pkg;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_CMD,
        S_DIV,
        S_RAMP,
        S_STEP,
        S_DONE
    } stramp_state_t;

    // result status codes
    localparam logic [1:0] ST_NONE   = 2'd0;
    localparam logic [1:0] ST_ACCEPT = 2'd1;
    localparam logic [1:0] ST_RANGE  = 2'd2;
    localparam logic [1:0] ST_BUSY   = 2'd3;

    // request kinds
    localparam logic REQ_TICK = 1'b0;
    localparam logic REQ_MOVE = 1'b1;

    // configuration register indexes
    localparam logic [2:0] CFG_START_DELAY  = 3'd0;
    localparam logic [2:0] CFG_CRUISE_DELAY = 3'd1;
    localparam logic [2:0] CFG_DELAY_STEP   = 3'd2;
    localparam logic [2:0] CFG_PULSE_TICKS  = 3'd3;
    localparam logic [2:0] CFG_TRAVEL_LIMIT = 3'd4;

    // configuration reset values
    localparam logic [15:0] RST_START_DELAY  = 16'd2500;
    localparam logic [15:0] RST_CRUISE_DELAY = 16'd1300;
    localparam logic [7:0]  RST_DELAY_STEP   = 8'd4;
    localparam logic [7:0]  RST_PULSE_TICKS  = 8'd10;
    localparam logic [10:0] RST_TRAVEL_LIMIT = 11'd2000;

    // divider operand widths
    localparam int DIV_DVD_BITS = 16;
    localparam int DIV_DVS_BITS = 8;

    // status word passed back from the divider
    typedef struct packed {
        logic                    done;
        logic [DIV_DVD_BITS-1:0] quotient;
    } stramp_div_res_t;

endpackage

`default_nettype wire

[rtl/stramp_div.sv]
// restoring serial divider, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none

module stramp_div (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    input  wire logic [stramp_pkg::DIV_DVD_BITS-1:0] dividend,
    input  wire logic [stramp_pkg::DIV_DVS_BITS-1:0] divisor,
    output stramp_pkg::stramp_div_res_t            res
);
    import stramp_pkg::*;

    localparam int CNT_BITS = $clog2(DIV_DVD_BITS + 1);

    logic [DIV_DVD_BITS-1:0] dvd_reg, dvd_next;
    logic [DIV_DVS_BITS-1:0] rem_reg, rem_next;
    logic [CNT_BITS-1:0]     cnt_reg, cnt_next;
    logic                    active_reg, active_next;
    logic                    done_reg, done_next;
    logic [DIV_DVS_BITS:0]   shifted;
    logic [DIV_DVS_BITS:0]   trial;

    always_comb
    begin
        shifted     = {rem_reg, dvd_reg[DIV_DVD_BITS-1]};
        trial       = shifted - {1'b0, divisor};
        dvd_next    = dvd_reg;
        rem_next    = rem_reg;
        cnt_next    = cnt_reg;
        active_next = active_reg;
        done_next   = 1'b0;
        if (start)
        begin
            dvd_next    = dividend;
            rem_next    = '0;
            cnt_next    = CNT_BITS'(DIV_DVD_BITS);
            active_next = 1'b1;
        end
        else if (active_reg)
        begin
            // trial subtract, shift the quotient bit in from the right
            if (shifted >= {1'b0, divisor})
            begin
                rem_next = trial[DIV_DVS_BITS-1:0];
                dvd_next = {dvd_reg[DIV_DVD_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[DIV_DVS_BITS-1:0];
                dvd_next = {dvd_reg[DIV_DVD_BITS-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_BITS'(1))
            begin
                active_next = 1'b0;
                done_next   = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            cnt_reg    <= cnt_next;
            active_reg <= active_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
    end

    assign res.done     = done_reg;
    assign res.quotient = dvd_reg;

endmodule

`default_nettype wire

[rtl/stepper_trapezoid_ramp_core.sv]
// stepper trapezoid ramp core: step pulse sequencer with serial ramp divide
//
// input channel (in_valid / in_ready) carries one word per request: req_type 0
// is a one-microsecond tick, req_type 1 a move command with an absolute
// target_steps. every accepted word yields exactly one result word on the
// output channel (out_valid / out_ready): step level for that tick,
// direction, busy flag, committed position and status.
// sequencing: the block takes one word at a time. a tick goes from S_CMD
// to S_DONE, through S_STEP at a step boundary to load the next step
// period. a move command that ramps goes through S_DIV, where the serial
// divide of (start_delay - cruise_delay) by delay_step sizes the ramp, then
// S_RAMP; a rejected move goes straight to S_DONE, a non-ramping one through
// S_RAMP. in_ready is high only while the sequencer is idle.
// a finished result sits in the output register; the next word is taken
// and worked on while it waits, and only the hand-over of that next result
// waits for the receiver.
// configuration (cfg_we, cfg_index, cfg_data) writes a register on cfg_we; indexes
// above four are ignored. write it only while idle.
// reset: asynchronous, active low; registers go to their defaults, position
// to zero, no move in progress, output channel empty.
`timescale 1ns / 1ps
`default_nettype none

module stepper_trapezoid_ramp_core #(
    parameter int DELAY_BITS = 16,
    parameter int COUNT_BITS = 13
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    // configuration write port
    input  wire logic               cfg_we,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [15:0]        cfg_data,
    // request words
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic               req_type,
    input  wire logic signed [11:0] target_steps,
    // result words
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic                    step_level,
    output logic                    dir_level,
    output logic                    busy_res,
    output logic signed [11:0]      position,
    output logic [1:0]              status
);
    import stramp_pkg::*;

    // working widths: delay math one bit above the widest delay operand
    localparam int WB = ((DELAY_BITS > 16) ? DELAY_BITS : 16) + 1;
    localparam int LB = (COUNT_BITS > 13) ? COUNT_BITS : 13;
    localparam int FB = (COUNT_BITS > 16) ? COUNT_BITS : 16;

    // configuration registers
    logic [15:0] start_delay_reg;
    logic [15:0] cruise_delay_reg;
    logic [7:0]  delay_step_reg;
    logic [7:0]  pulse_ticks_reg;
    logic [10:0] travel_limit_reg;

    // sequencer and move state
    stramp_state_t          state_reg, state_next;
    logic                   req_type_reg;
    logic signed [11:0]     target_reg;
    logic signed [11:0]     cur_pos_reg, cur_pos_next;
    logic [COUNT_BITS-1:0]  move_length_reg, move_length_next;
    logic [COUNT_BITS-1:0]  step_index_reg, step_index_next;
    logic [COUNT_BITS-1:0]  ramp_reg, ramp_next;
    logic [FB-1:0]          full_reg, full_next;
    logic [DELAY_BITS-1:0]  period_reg, period_next;
    logic [DELAY_BITS-1:0]  tick_reg, tick_next;
    logic                   moving_reg, moving_next;
    logic                   dir_reg, dir_next;
    logic                   step_pend_reg, step_pend_next;
    logic [1:0]             status_pend_reg, status_pend_next;

    // output register
    logic                   out_valid_reg, out_valid_next;
    logic                   load_out;

    // divider hookup
    logic                   div_start;
    stramp_div_res_t        div_res;

    // command decode
    logic [11:0]            target_mag;
    logic                   target_bad;
    logic signed [12:0]     diff;
    logic [12:0]            diff_abs;
    logic [LB-1:0]          diff_ext;
    logic                   ramp_ok;

    // tick decode
    logic [WB-1:0]          tk_plen;
    logic [WB-1:0]          tk_next;
    logic [WB-1:0]          tk_pulse;
    logic [COUNT_BITS-1:0]  si_inc;
    logic                   period_end;
    logic                   move_end;
    logic [LB-1:0]          ml_ext;
    logic [11:0]            ml12;

    // step period update
    logic [WB-1:0]          bs_d;
    logic [WB-1:0]          bs_ds;
    logic [WB-1:0]          bs_cruise;
    logic [WB-1:0]          bs_max;
    logic [FB-1:0]          half_ext;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign load_out  = (state_reg == S_DONE) && (!out_valid_reg || out_ready);

    stramp_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (start_delay_reg - cruise_delay_reg),
        .divisor  (delay_step_reg),
        .res      (div_res)
    );

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_delay_reg  <= RST_START_DELAY;
            cruise_delay_reg <= RST_CRUISE_DELAY;
            delay_step_reg   <= RST_DELAY_STEP;
            pulse_ticks_reg  <= RST_PULSE_TICKS;
            travel_limit_reg <= RST_TRAVEL_LIMIT;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_START_DELAY:  start_delay_reg  <= cfg_data;
                CFG_CRUISE_DELAY: cruise_delay_reg <= cfg_data;
                CFG_DELAY_STEP:   delay_step_reg   <= cfg_data[7:0];
                CFG_PULSE_TICKS:  pulse_ticks_reg  <= cfg_data[7:0];
                CFG_TRAVEL_LIMIT: travel_limit_reg <= cfg_data[10:0];
                default: ;
            endcase
        end
    end

    // shared decode terms
    always_comb
    begin
        // move command checks
        target_mag = target_reg[11] ? 12'(-target_reg) : 12'(target_reg);
        target_bad = target_mag > {1'b0, travel_limit_reg};
        diff       = 13'(signed'(target_reg)) - 13'(signed'(cur_pos_reg));
        diff_abs   = diff[12] ? 13'(-diff) : 13'(diff);
        diff_ext   = LB'(diff_abs);
        ramp_ok    = (start_delay_reg > cruise_delay_reg) && (delay_step_reg != 8'd0);

        // tick: period length is at least the pulse width
        tk_pulse   = WB'(pulse_ticks_reg);
        tk_plen    = (WB'(period_reg) > tk_pulse) ? WB'(period_reg) : tk_pulse;
        tk_next    = WB'(tick_reg) + WB'(1);
        period_end = (tk_next >= tk_plen);
        si_inc     = step_index_reg + 1'b1;
        move_end   = (si_inc >= move_length_reg);
        ml_ext     = LB'(move_length_reg);
        ml12       = ml_ext[11:0];

        // ramp length is the smaller of the slope and half the move
        half_ext   = FB'(move_length_reg >> 1);

        // next step period: down on the ramp in, up on the ramp out, cruise floor
        bs_ds      = WB'(delay_step_reg);
        bs_cruise  = WB'(cruise_delay_reg);
        bs_max     = WB'({DELAY_BITS{1'b1}});
        bs_d       = WB'(period_reg);
        if (step_index_reg < ramp_reg)
        begin
            bs_d = (bs_d >= bs_ds) ? (bs_d - bs_ds) : '0;
        end
        else if (step_index_reg >= (move_length_reg - ramp_reg))
        begin
            bs_d = bs_d + bs_ds;
            if (bs_d > bs_max)
            begin
                bs_d = bs_max;
            end
        end
        if (bs_d < bs_cruise)
        begin
            bs_d = bs_cruise;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_CMD;
                end
            end
            S_CMD:
            begin
                if (req_type_reg == REQ_MOVE)
                begin
                    if (moving_reg || target_bad)
                    begin
                        state_next = S_DONE;
                    end
                    else if (ramp_ok)
                    begin
                        state_next = S_DIV;
                    end
                    else
                    begin
                        state_next = S_RAMP;
                    end
                end
                else if (moving_reg && period_end && !move_end)
                begin
                    state_next = S_STEP;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_DIV:
            begin
                if (div_res.done)
                begin
                    state_next = S_RAMP;
                end
            end
            S_RAMP:
            begin
                state_next = (move_length_reg != '0) ? S_STEP : S_DONE;
            end
            S_STEP:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (load_out)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // datapath updates per state
    always_comb
    begin
        cur_pos_next     = cur_pos_reg;
        move_length_next = move_length_reg;
        step_index_next  = step_index_reg;
        ramp_next        = ramp_reg;
        full_next        = full_reg;
        period_next      = period_reg;
        tick_next        = tick_reg;
        moving_next      = moving_reg;
        dir_next         = dir_reg;
        step_pend_next   = step_pend_reg;
        status_pend_next = status_pend_reg;
        div_start        = 1'b0;
        out_valid_next   = out_valid_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                step_pend_next   = 1'b0;
                status_pend_next = ST_NONE;
            end
            S_CMD:
            begin
                if (req_type_reg == REQ_MOVE)
                begin
                    if (moving_reg)
                    begin
                        status_pend_next = ST_BUSY;
                    end
                    else if (target_bad)
                    begin
                        status_pend_next = ST_RANGE;
                    end
                    else
                    begin
                        status_pend_next = ST_ACCEPT;
                        dir_next         = !diff[12] && (diff != 13'sd0);
                        move_length_next = diff_ext[COUNT_BITS-1:0];
                        step_index_next  = '0;
                        period_next      = DELAY_BITS'(start_delay_reg);
                        div_start        = ramp_ok;
                        // no slope: ramp length zero, flat delay
                        if (start_delay_reg <= cruise_delay_reg)
                        begin
                            full_next = '0;
                        end
                        else
                        begin
                            full_next = FB'(diff_ext[COUNT_BITS-1:0]);
                        end
                    end
                end
                else if (moving_reg)
                begin
                    step_pend_next = (WB'(tick_reg) < tk_pulse);
                    if (period_end)
                    begin
                        step_index_next = si_inc;
                        if (move_end)
                        begin
                            cur_pos_next = dir_reg ? (cur_pos_reg + signed'(ml12))
                                                   : (cur_pos_reg - signed'(ml12));
                            moving_next  = 1'b0;
                            tick_next    = '0;
                        end
                    end
                    else
                    begin
                        tick_next = tk_next[DELAY_BITS-1:0];
                    end
                end
            end
            S_DIV:
            begin
                if (div_res.done)
                begin
                    full_next = FB'(div_res.quotient);
                end
            end
            S_RAMP:
            begin
                ramp_next = (half_ext < full_reg) ? move_length_reg >> 1
                                                  : full_reg[COUNT_BITS-1:0];
                if (move_length_reg != '0)
                begin
                    moving_next = 1'b1;
                end
            end
            S_STEP:
            begin
                period_next = bs_d[DELAY_BITS-1:0];
                tick_next   = '0;
            end
            S_DONE:
            begin
                if (load_out)
                begin
                    out_valid_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            cur_pos_reg     <= '0;
            move_length_reg <= '0;
            step_index_reg  <= '0;
            ramp_reg        <= '0;
            period_reg      <= '0;
            tick_reg        <= '0;
            moving_reg      <= 1'b0;
            dir_reg         <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            cur_pos_reg     <= cur_pos_next;
            move_length_reg <= move_length_next;
            step_index_reg  <= step_index_next;
            ramp_reg        <= ramp_next;
            period_reg      <= period_next;
            tick_reg        <= tick_next;
            moving_reg      <= moving_next;
            dir_reg         <= dir_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            req_type_reg <= req_type;
            target_reg   <= target_steps;
        end
        full_reg        <= full_next;
        step_pend_reg   <= step_pend_next;
        status_pend_reg <= status_pend_next;
        if (load_out)
        begin
            step_level <= step_pend_reg;
            dir_level  <= dir_reg;
            busy_res   <= moving_reg;
            position   <= cur_pos_reg;
            status     <= status_pend_reg;
        end
    end

    // a running move always has steps left
    a_moving_len: assert property (@(posedge clk) disable iff (!rst_n)
        moving_reg |-> (step_index_reg < move_length_reg))
        else $error("step index ran past move length");

    // ramp never exceeds half of the move
    a_ramp_half: assert property (@(posedge clk) disable iff (!rst_n)
        moving_reg |-> (ramp_reg <= (move_length_reg >> 1)))
        else $error("ramp longer than half the move");

    // divider only finishes while the sequencer waits for it
    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        div_res.done |-> (state_reg == S_DIV))
        else $error("divider result outside divide state");

    // a pending result stays in the output register until the receiver takes it
    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> out_valid_reg)
        else $error("pending result dropped");

endmodule

`default_nettype wire
